// ----- rtl/lkvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared types and constants for the LRU key-value cache core and its
// channel interfaces.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    // Width of a key or a stored value.
    localparam int DATA_W = 32;

    // Width of the capacity register.
    localparam int CAP_W = 4;

    // Default number of physical entries.
    localparam int CAPACITY_DEFAULT = 8;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CAP_W-1:0]         cap_t;

    // Request codes.
    typedef enum logic
    {
        REQ_GET = 1'b0,
        REQ_PUT = 1'b1
    } req_type_t;

    // Capacity register value after reset.
    localparam cap_t CAP_RESET = cap_t'(8);

    // Read value returned by a get that misses, and by every put.
    localparam data_t GET_MISS_VALUE = data_t'(-1);
    localparam data_t PUT_READ_VALUE = data_t'(0);

endpackage

// ----- rtl/lkvc_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache channel interfaces
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface lkvc_req_if
    import lkvc_pkg::*;
();
    logic      valid;
    logic      ready;
    req_type_t req_type;
    data_t     key;
    data_t     value;

    modport source
    (
        output valid,
        input  ready,
        output req_type,
        output key,
        output value
    );

    modport sink
    (
        input  valid,
        output ready,
        input  req_type,
        input  key,
        input  value
    );
endinterface

interface lkvc_rsp_if
    import lkvc_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  found;
    data_t read_value;

    modport source
    (
        output valid,
        input  ready,
        output found,
        output read_value
    );

    modport sink
    (
        input  valid,
        output ready,
        input  found,
        input  read_value
    );
endinterface

// ----- rtl/lru_key_value_cache_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache core
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The core takes one request word (get or put) per clock cycle while it is
// not stalled and returns exactly one response word for each, in order. A
// request is registered in the input register on acceptance; once the output
// register is free it is compared against all entries in parallel, the
// recency ranks and the entry contents are updated, and the response is
// loaded into the output register. The sustained rate is one word per cycle
// while responses are taken; the input side keeps taking words while a
// response waits to be taken, and only stalls when both the input register
// and the output register are full.
// A get that hits returns the stored value and makes the entry most recent;
// a get that misses returns found = 0 with read value -1. A put updates or
// inserts the pair as most recent, with read value 0 and found = hit. When
// the store already holds cfg capacity entries, a put miss evicts the least
// recent one. The capacity register (cfg_wdata on cfg_we) takes effect
// between 1 and CAPACITY: 0 acts as 1 and larger values act as CAPACITY.
// Lowering it below the current fill does not drop entries; each later put
// miss replaces the least recent entry. Write it only while the core is idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core
    import lkvc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    lkvc_req_if.sink       req,
    lkvc_rsp_if.source     rsp,
    input  logic           cfg_we,
    input  cap_t           cfg_wdata
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    cap_t          cap_reg;

    logic          in_valid_reg;
    req_type_t     in_type_reg;
    data_t         in_key_reg;
    data_t         in_value_reg;

    logic          rsp_valid_reg;
    logic          found_reg;
    data_t         read_value_reg;

    // Entry contents are only read while the entry is valid, so they
    // carry no reset.
    data_t         entry_key_reg  [CAPACITY];
    data_t         entry_data_reg [CAPACITY];
    logic [CAPACITY-1:0] entry_valid_reg;
    logic [CAPACITY-1:0] entry_valid_next;
    rank_t         rank_reg  [CAPACITY];
    rank_t         rank_next [CAPACITY];
    cnt_t          count_reg;
    cnt_t          count_next;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic in_fire;
    logic out_free;
    logic proc;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign proc      = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || proc;
    assign in_fire   = req.valid && req.ready;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.found      = found_reg;
    assign rsp.read_value = read_value_reg;

    // ------------------------------------------------------------------
    // Lookup and replacement decision
    // ------------------------------------------------------------------
    logic [CAPACITY-1:0] match_vec;
    logic  hit;
    idx_t  hit_idx;
    idx_t  free_idx;
    idx_t  lru_idx;
    idx_t  slot;
    cnt_t  eff_cap;
    cnt_t  limit;
    logic  full;
    logic  is_put;
    logic  update_rank;
    logic  write_data;
    logic  write_key;
    rank_t lru_rank;

    // Effective capacity is the register clamped into 1..CAPACITY.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = cnt_t'(1);
        end
        else if ({{(32-CAP_W){1'b0}}, cap_reg} > 32'(CAPACITY))
        begin
            eff_cap = cnt_t'(CAPACITY);
        end
        else
        begin
            eff_cap = cnt_t'(cap_reg);
        end
    end

    assign is_put   = (in_type_reg == REQ_PUT);
    assign full     = (count_reg >= eff_cap);
    assign lru_rank = rank_t'(count_reg - cnt_t'(1));

    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            match_vec[j] = entry_valid_reg[j] && (entry_key_reg[j] == in_key_reg);
        end
        // Lowest-numbered match; keys are unique, so at most one matches.
        for (int j = CAPACITY - 1; j >= 0; j--)
        begin
            if (match_vec[j])
            begin
                hit     = 1'b1;
                hit_idx = idx_t'(j);
            end
            if (!entry_valid_reg[j])
            begin
                free_idx = idx_t'(j);
            end
            // Valid ranks are distinct 0..count-1, so the oldest entry is
            // the one whose rank is count-1.
            if (entry_valid_reg[j] && (rank_reg[j] == lru_rank))
            begin
                lru_idx = idx_t'(j);
            end
        end
    end

    always_comb
    begin
        if (hit)
        begin
            slot  = hit_idx;
            limit = cnt_t'(rank_reg[hit_idx]);
        end
        else if (full)
        begin
            slot  = lru_idx;
            limit = count_reg - cnt_t'(1);
        end
        else
        begin
            slot  = free_idx;
            limit = count_reg;
        end
    end

    assign update_rank = proc && (hit || is_put);
    assign write_data  = proc && is_put;
    assign write_key   = proc && is_put && !hit;

    // ------------------------------------------------------------------
    // Recency, valid and fill updates
    // ------------------------------------------------------------------
    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        count_next       = count_reg;
        for (int j = 0; j < CAPACITY; j++)
        begin
            rank_next[j] = rank_reg[j];
            if (update_rank)
            begin
                if (idx_t'(j) == slot)
                begin
                    rank_next[j] = '0;
                end
                else if (entry_valid_reg[j] && (cnt_t'(rank_reg[j]) < limit))
                begin
                    rank_next[j] = rank_reg[j] + rank_t'(1);
                end
            end
        end
        if (write_key)
        begin
            entry_valid_next[slot] = 1'b1;
            if (!full)
            begin
                count_next = count_reg + cnt_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            count_reg       <= '0;
            for (int j = 0; j < CAPACITY; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
            count_reg       <= count_next;
            for (int j = 0; j < CAPACITY; j++)
            begin
                rank_reg[j] <= rank_next[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_data)
        begin
            entry_data_reg[slot] <= in_value_reg;
        end
        if (write_key)
        begin
            entry_key_reg[slot] <= in_key_reg;
        end
    end

    // ------------------------------------------------------------------
    // Configuration, input register and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_type_reg  <= req.req_type;
            in_key_reg   <= req.key;
            in_value_reg <= req.value;
        end
        if (proc)
        begin
            found_reg <= hit;
            if (is_put)
            begin
                read_value_reg <= PUT_READ_VALUE;
            end
            else if (hit)
            begin
                read_value_reg <= entry_data_reg[hit_idx];
            end
            else
            begin
                read_value_reg <= GET_MISS_VALUE;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_matches_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        $countones(entry_valid_reg) == 32'(count_reg))
        else $error("fill count differs from number of valid entries");

    a_count_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_unique_keys: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> $onehot0(match_vec))
        else $error("key matches more than one valid entry");

    a_put_leaves_entry: assert property (
        @(posedge clk) disable iff (!rst_n)
        (proc && is_put) |=> (count_reg != '0))
        else $error("store empty after a put");

    a_response_follows: assert property (
        @(posedge clk) disable iff (!rst_n)
        proc |=> rsp_valid_reg)
        else $error("processed request produced no response");

endmodule
